// ===== rtl/u2cp_pkg.sv =====
`timescale 1ns / 1ps

package u2cp_pkg;

  localparam int PAGES_DEF = 4;
  localparam int ENTRIES   = 128;
  localparam int ENTRY_W   = 7;
  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 16;
  localparam int INDEX_W   = 9;
  localparam int POINT_W   = 21;
  localparam int PIU_W     = 3;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [BYTE_W-1:0]  REPL          = 8'h7F;
  localparam logic [WORD_W-1:0]  CODE_PAGE_RST = 16'd437;
  localparam logic [POINT_W-1:0] LOW_2BYTE     = 21'h00080;
  localparam logic [POINT_W-1:0] LOW_3BYTE     = 21'h00800;
  localparam logic [POINT_W-1:0] LOW_4BYTE     = 21'h10000;
  localparam logic [POINT_W-1:0] SURR_LO       = 21'h0D800;
  localparam logic [POINT_W-1:0] SURR_HI       = 21'h0DFFF;

  typedef enum logic [1:0] {
    ACT_DECODE     = 2'd0,
    ACT_LOAD_TABLE = 2'd1,
    ACT_LOAD_ID    = 2'd2,
    ACT_UNUSED     = 2'd3
  } action_t;

  typedef enum logic {
    REG_CODE_PAGE    = 1'b0,
    REG_PAGES_IN_USE = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SLOT,
    ST_TABLE,
    ST_EMIT_A,
    ST_EMIT_B
  } state_t;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_ONE,
    EV_TWO,
    EV_MAP
  } eval_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic slot_step;
    logic tbl_start;
    logic tbl_step;
    logic map_hit;
    logic repl;
    logic out_first;
    logic out_second;
  } u2cp_cmd_t;

  typedef struct packed {
    eval_t ev;
    logic  two;
    logic  out_free;
    logic  slot_hit;
    logic  slot_end;
    logic  entry_hit;
    logic  entry_end;
  } u2cp_sts_t;

endpackage

// ===== rtl/u2cp_if.sv =====
`timescale 1ns / 1ps

interface u2cp_in_if import u2cp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  action_t              action;
  logic [BYTE_W-1:0]    byte_in;
  logic [INDEX_W-1:0]   load_index;
  logic [WORD_W-1:0]    load_word;

  modport source (output valid, action, byte_in, load_index, load_word, input ready);
  modport sink   (input valid, action, byte_in, load_index, load_word, output ready);
endinterface

interface u2cp_out_if import u2cp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] oem_byte;
  logic              last;

  modport source (output valid, oem_byte, last, input ready);
  modport sink   (input valid, oem_byte, last, output ready);
endinterface

// ===== rtl/utf8_to_code_page_decoder.sv =====
`timescale 1ns / 1ps

// Decodes a stream of UTF-8 bytes into single-byte code-page characters, one result per
// completed character: ASCII passes through, a NUL gives 0 and resets the decoder, and every
// malformed, unsupported or unmapped character gives 0x7F. Items are taken one at a time.
// A completed multi-byte character is looked up: the page slots are checked in turn (at most
// PAGES, and no more than pages_in_use), then up to the page's 128 table words are read one
// per cycle through the single read port of the table memory. A waiting result sits in the
// output register while the next item is accepted. Page ids and table words must be loaded
// before they are used; the tables need no clearing pass.

module utf8_to_code_page_decoder import u2cp_pkg::*; #(
  parameter int PAGES = PAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  u2cp_in_if.sink            in_ch,
  u2cp_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [WORD_W-1:0] code_page_r;
  logic [PIU_W-1:0]  pages_in_use_r;
  logic              cfg_wr;
  reg_idx_t          cfg_reg;
  u2cp_cmd_t         cmd;
  u2cp_sts_t         sts;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_reg = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_page_r    <= CODE_PAGE_RST;
      pages_in_use_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg)
        REG_CODE_PAGE:    code_page_r    <= pwdata[WORD_W-1:0];
        REG_PAGES_IN_USE: pages_in_use_r <= pwdata[PIU_W-1:0];
        default:          code_page_r    <= code_page_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_PAGES_IN_USE: prdata = PDATA_W'(pages_in_use_r);
      default:          prdata = PDATA_W'(code_page_r);
    endcase
  end

  u2cp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  u2cp_dp #(
    .PAGES (PAGES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .action       (in_ch.action),
    .byte_in      (in_ch.byte_in),
    .load_index   (in_ch.load_index),
    .load_word    (in_ch.load_word),
    .code_page    (code_page_r),
    .pages_in_use (pages_in_use_r),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_byte     (out_ch.oem_byte),
    .out_last     (out_ch.last)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while an earlier item is still in work");

  a_pair_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last) |=> out_ch.valid)
    else $error("second result of a pair not presented straight after the first");

  a_pair_leads_repl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last) |-> (out_ch.oem_byte == REPL))
    else $error("first result of a pair is not the replacement byte");

endmodule

// ===== rtl/u2cp_ctrl.sv =====
`timescale 1ns / 1ps

module u2cp_ctrl import u2cp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  u2cp_sts_t sts,
  output u2cp_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        case (sts.ev)
          EV_ONE, EV_TWO: state_nxt = ST_EMIT_A;
          EV_MAP:         state_nxt = ST_SLOT;
          default:        state_nxt = ST_IDLE;
        endcase
      end
      ST_SLOT: begin
        if (sts.slot_end) state_nxt = ST_EMIT_A;
        else if (sts.slot_hit) state_nxt = ST_TABLE;
      end
      ST_TABLE: begin
        if (sts.entry_hit || sts.entry_end) state_nxt = ST_EMIT_A;
      end
      ST_EMIT_A: begin
        if (sts.out_free) state_nxt = sts.two ? ST_EMIT_B : ST_IDLE;
      end
      ST_EMIT_B: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      ST_SLOT: begin
        cmd.repl      = sts.slot_end;
        cmd.tbl_start = !sts.slot_end && sts.slot_hit;
        cmd.slot_step = !sts.slot_end && !sts.slot_hit;
      end
      ST_TABLE: begin
        cmd.tbl_step = 1'b1;
        cmd.map_hit  = sts.entry_hit;
        cmd.repl     = sts.entry_end;
      end
      ST_EMIT_A: begin
        cmd.out_first = sts.out_free;
      end
      ST_EMIT_B: begin
        cmd.out_second = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/u2cp_dp.sv =====
`timescale 1ns / 1ps

module u2cp_dp import u2cp_pkg::*; #(
  parameter int PAGES = PAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  action_t            action,
  input  logic [BYTE_W-1:0]  byte_in,
  input  logic [INDEX_W-1:0] load_index,
  input  logic [WORD_W-1:0]  load_word,
  input  logic [WORD_W-1:0]  code_page,
  input  logic [PIU_W-1:0]   pages_in_use,
  input  u2cp_cmd_t          cmd,
  output u2cp_sts_t          sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               out_last
);

  localparam int TABLE_WORDS = PAGES * ENTRIES;
  localparam int TBL_W       = $clog2(TABLE_WORDS);
  localparam int SLOT_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int LIM_W       = ($clog2(PAGES + 1) > PIU_W) ? $clog2(PAGES + 1) : PIU_W;

  action_t             action_r;
  logic [BYTE_W-1:0]   byte_r;
  logic [INDEX_W-1:0]  index_r;
  logic [WORD_W-1:0]   word_r;

  logic [POINT_W-1:0]  pp_r, pp_nxt;
  logic [1:0]          due_r, due_nxt;
  logic [1:0]          extra_r, extra_nxt;

  logic [BYTE_W-1:0]   v1_r, v2_r;
  logic                two_r;
  logic [WORD_W-1:0]   pt_r;

  logic [LIM_W-1:0]    slot_cnt_r;
  logic [LIM_W-1:0]    limit;
  logic [ENTRY_W:0]    rd_idx_r;
  logic [ENTRY_W-1:0]  cmp_idx_r;
  logic                cmp_vld_r;
  logic                issue;

  logic [WORD_W-1:0]   ids_r [PAGES];
  logic [WORD_W-1:0]   tbl_mem [TABLE_WORDS];
  logic [WORD_W-1:0]   rdata_r;
  logic                tbl_we;
  logic                id_we;
  logic [TBL_W-1:0]    waddr;
  logic [TBL_W-1:0]    raddr;

  logic                out_valid_r;
  logic [BYTE_W-1:0]   out_byte_r;
  logic                out_last_r;

  logic [POINT_W-1:0]  cont_point;
  logic [POINT_W-1:0]  min_point;
  logic                point_bad;
  logic                lead_emit;
  logic [BYTE_W-1:0]   lead_val;
  logic [POINT_W-1:0]  lead_pp;
  logic [1:0]          lead_due;
  eval_t               ev;
  logic [BYTE_W-1:0]   v1, v2;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= action;
      byte_r   <= byte_in;
      index_r  <= load_index;
      word_r   <= load_word;
    end
  end

  always_comb begin
    cont_point = {pp_r[POINT_W-7:0], byte_r[5:0]};
    case (extra_r)
      2'd1:    min_point = LOW_2BYTE;
      2'd2:    min_point = LOW_3BYTE;
      2'd3:    min_point = LOW_4BYTE;
      default: min_point = '0;
    endcase
    point_bad = (cont_point < min_point) || (cont_point >= LOW_4BYTE) ||
                ((cont_point >= SURR_LO) && (cont_point <= SURR_HI));

    lead_emit = 1'b0;
    lead_val  = byte_r;
    lead_pp   = '0;
    lead_due  = 2'd0;
    if (byte_r inside {[8'h00:8'h7F]}) begin
      lead_emit = 1'b1;
    end else if (byte_r inside {[8'hC0:8'hDF]}) begin
      lead_pp  = POINT_W'(byte_r[4:0]);
      lead_due = 2'd1;
    end else if (byte_r inside {[8'hE0:8'hEF]}) begin
      lead_pp  = POINT_W'(byte_r[3:0]);
      lead_due = 2'd2;
    end else if (byte_r inside {[8'hF0:8'hF7]}) begin
      lead_pp  = POINT_W'(byte_r[2:0]);
      lead_due = 2'd3;
    end else begin
      lead_emit = 1'b1;
      lead_val  = REPL;
    end

    pp_nxt    = pp_r;
    due_nxt   = due_r;
    extra_nxt = extra_r;
    ev        = EV_NONE;
    v1        = REPL;
    v2        = REPL;
    if (action_r == ACT_DECODE) begin
      if ((due_r != 2'd0) && (byte_r[7:6] == 2'b10)) begin
        pp_nxt  = cont_point;
        due_nxt = due_r - 2'd1;
        if (due_r == 2'd1) begin
          pp_nxt    = '0;
          extra_nxt = 2'd0;
          ev        = point_bad ? EV_ONE : EV_MAP;
        end
      end else begin
        pp_nxt    = lead_pp;
        due_nxt   = lead_due;
        extra_nxt = lead_due;
        if (due_r != 2'd0) begin
          ev = lead_emit ? EV_TWO : EV_ONE;
          v2 = lead_val;
        end else if (lead_emit) begin
          ev = EV_ONE;
          v1 = lead_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r    <= '0;
      due_r   <= 2'd0;
      extra_r <= 2'd0;
    end else if (cmd.eval && (action_r == ACT_DECODE)) begin
      pp_r    <= pp_nxt;
      due_r   <= due_nxt;
      extra_r <= extra_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      v1_r  <= v1;
      v2_r  <= v2;
      two_r <= (ev == EV_TWO);
      pt_r  <= cont_point[WORD_W-1:0];
    end else if (cmd.map_hit) begin
      v1_r <= {1'b1, cmp_idx_r};
    end else if (cmd.repl) begin
      v1_r <= REPL;
    end
  end

  assign limit = (LIM_W'(pages_in_use) > LIM_W'(PAGES)) ? LIM_W'(PAGES) : LIM_W'(pages_in_use);
  assign issue = cmd.tbl_step && !rd_idx_r[ENTRY_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_cnt_r <= '0;
      rd_idx_r   <= '0;
      cmp_vld_r  <= 1'b0;
    end else begin
      if (cmd.eval) begin
        slot_cnt_r <= '0;
      end else if (cmd.slot_step) begin
        slot_cnt_r <= slot_cnt_r + LIM_W'(1);
      end
      if (cmd.tbl_start) begin
        rd_idx_r  <= '0;
        cmp_vld_r <= 1'b0;
      end else if (cmd.tbl_step) begin
        if (issue) rd_idx_r <= rd_idx_r + (ENTRY_W + 1)'(1);
        cmp_vld_r <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) cmp_idx_r <= rd_idx_r[ENTRY_W-1:0];
  end

  assign tbl_we = cmd.eval && (action_r == ACT_LOAD_TABLE) &&
                  (32'(index_r) < 32'(TABLE_WORDS));
  assign id_we  = cmd.eval && (action_r == ACT_LOAD_ID) && (32'(index_r) < 32'(PAGES));
  assign waddr  = TBL_W'(index_r);
  assign raddr  = TBL_W'({slot_cnt_r[SLOT_W-1:0], rd_idx_r[ENTRY_W-1:0]});

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[waddr] <= word_r;
    rdata_r <= tbl_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (id_we) ids_r[index_r[SLOT_W-1:0]] <= word_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_first || cmd.out_second) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_first) begin
      out_byte_r <= v1_r;
      out_last_r <= !two_r;
    end else if (cmd.out_second) begin
      out_byte_r <= v2_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  always_comb begin
    sts.ev        = ev;
    sts.two       = two_r;
    sts.out_free  = !out_valid_r || out_ready;
    sts.slot_end  = (slot_cnt_r >= limit);
    sts.slot_hit  = (ids_r[slot_cnt_r[SLOT_W-1:0]] == code_page);
    sts.entry_hit = cmp_vld_r && (rdata_r == pt_r);
    sts.entry_end = cmp_vld_r && (cmp_idx_r == ENTRY_W'(ENTRIES - 1)) && (rdata_r != pt_r);
  end

endmodule

// ===== bench/u2cp_result_checker.sv =====
`timescale 1ns / 1ps

module u2cp_result_checker import u2cp_pkg::*; #(
  parameter int PAGES = PAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  u2cp_in_if                 in_mon,
  u2cp_out_if                out_mon,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);

  localparam logic [POINT_W-1:0] MAX_POINT = 21'h10FFFF;
  localparam int                 SHOWN_MAX = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] oem_byte;
    logic              last;
  } oem_result_t;

  logic [WORD_W-1:0]  code_page_reg;
  logic [PIU_W-1:0]   pages_used;
  logic [POINT_W-1:0] point_acc;
  logic [1:0]         cont_due;
  logic [1:0]         cont_total;
  logic [WORD_W-1:0]  slot_id [PAGES];
  logic [WORD_W-1:0]  page_words [PAGES*ENTRIES];
  oem_result_t        expected_oem [$];
  int                 failures = 0;

  function automatic logic [BYTE_W-1:0] map_to_page(logic [POINT_W-1:0] cp);
    int limit;
    int slot;
    limit = (pages_used > PAGES) ? PAGES : int'(pages_used);
    if (cp < 21'h80) return cp[BYTE_W-1:0];
    if (cp >= LOW_4BYTE) return REPL;
    if (cp >= SURR_LO && cp <= SURR_HI) return REPL;
    slot = 0;
    while (slot < limit && slot_id[slot] != code_page_reg) slot++;
    if (slot >= limit) return REPL;
    for (int k = 0; k < ENTRIES; k++) begin
      if (page_words[slot*ENTRIES + k] == cp[WORD_W-1:0]) return BYTE_W'(k + 'h80);
    end
    return REPL;
  endfunction

  function automatic logic [BYTE_W-1:0] finish_char();
    logic [POINT_W-1:0] cp;
    logic [POINT_W-1:0] floor_point;
    cp = point_acc;
    case (cont_total)
      2'd1: begin
        floor_point = LOW_2BYTE;
      end
      2'd2: begin
        floor_point = LOW_3BYTE;
      end
      2'd3: begin
        floor_point = LOW_4BYTE;
      end
      default: begin
        floor_point = '0;
      end
    endcase
    point_acc  = '0;
    cont_due   = '0;
    cont_total = '0;
    if (cp < floor_point || cp > MAX_POINT) return REPL;
    return map_to_page(cp);
  endfunction

  function automatic logic start_char(logic [BYTE_W-1:0] b, output logic [BYTE_W-1:0] res);
    res = REPL;
    if (b < 8'h80) begin
      res = b;
      return 1'b1;
    end
    if (b[7:5] == 3'b110) begin
      point_acc  = POINT_W'(b[4:0]);
      cont_due   = 2'd1;
      cont_total = 2'd1;
      return 1'b0;
    end
    if (b[7:4] == 4'b1110) begin
      point_acc  = POINT_W'(b[3:0]);
      cont_due   = 2'd2;
      cont_total = 2'd2;
      return 1'b0;
    end
    if (b[7:3] == 5'b11110) begin
      point_acc  = POINT_W'(b[2:0]);
      cont_due   = 2'd3;
      cont_total = 2'd3;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_oem(logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] res [2];
    logic [BYTE_W-1:0] lead_res;
    oem_result_t       entry;
    int                n;
    logic              open_new;
    n = 0;
    open_new = 1'b1;
    if (cont_due != 0) begin
      if (b[7:6] == 2'b10) begin
        point_acc = {point_acc[POINT_W-7:0], b[5:0]};
        cont_due  = cont_due - 2'd1;
        if (cont_due == 0) begin
          res[n] = finish_char();
          n++;
        end
        open_new = 1'b0;
      end else begin
        // A broken sequence is replaced, and the byte then starts afresh.
        res[n] = REPL;
        n++;
        point_acc  = '0;
        cont_due   = '0;
        cont_total = '0;
      end
    end
    if (open_new) begin
      if (b == 0) begin
        res[n] = '0;
        n++;
      end else if (start_char(b, lead_res)) begin
        res[n] = lead_res;
        n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      entry.oem_byte = res[k];
      entry.last     = (k == n - 1);
      expected_oem.push_back(entry);
    end
  endfunction

  always @(posedge clk) begin
    oem_result_t got;
    oem_result_t want;
    if (!rst_n) begin
      code_page_reg = CODE_PAGE_RST;
      pages_used    = '0;
      point_acc     = '0;
      cont_due      = '0;
      cont_total    = '0;
      expected_oem.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_CODE_PAGE, 2'b00}) begin
          code_page_reg = pwdata[WORD_W-1:0];
        end else if (paddr == {REG_PAGES_IN_USE, 2'b00}) begin
          pages_used = pwdata[PIU_W-1:0];
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got.oem_byte = out_mon.oem_byte;
        got.last     = out_mon.last;
        if (expected_oem.size() == 0) begin
          failures++;
          if (failures <= SHOWN_MAX) begin
            $display("unexpected result: oem_byte=%h last=%b", got.oem_byte, got.last);
          end
        end else begin
          want = expected_oem.pop_front();
          if (got.oem_byte !== want.oem_byte || got.last !== want.last) begin
            failures++;
            if (failures <= SHOWN_MAX) begin
              $display("mismatch: oem_byte expected %h got %h, last expected %b got %b",
                       want.oem_byte, got.oem_byte, want.last, got.last);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.action)
          ACT_DECODE: begin
            predict_oem(in_mon.byte_in);
          end
          ACT_LOAD_TABLE: begin
            if (in_mon.load_index < PAGES*ENTRIES) page_words[in_mon.load_index] = in_mon.load_word;
          end
          ACT_LOAD_ID: begin
            if (in_mon.load_index < PAGES) slot_id[in_mon.load_index] = in_mon.load_word;
          end
          default: begin
          end
        endcase
      end
    end
    fail_count <= failures;
    pending    <= expected_oem.size();
  end

endmodule

// ===== bench/tb_utf8_to_code_page_decoder.sv =====
`timescale 1ns / 1ps

module tb_utf8_to_code_page_decoder;
  import u2cp_pkg::*;

  localparam int PAGES        = PAGES_DEF;
  localparam int FILLED_PAGES = 2;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 17;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_AT      = 320;
  localparam int HOLD_CYCLES  = 400;
  localparam int CALM_FROM    = 360;
  localparam int CALM_TO      = 430;
  localparam int IDLE_PCT     = 24;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;
  int                 accepted_items = 0;
  int                 effective_items = 0;
  logic [WORD_W-1:0]  shadow_ids [PAGES];
  logic [WORD_W-1:0]  shadow_words [PAGES*ENTRIES];
  logic [WORD_W-1:0]  cur_page;
  logic [PIU_W-1:0]   cur_used;
  int                 phase_pages [PHASES];
  int                 phase_used [PHASES];

  u2cp_in_if  in_ch ();
  u2cp_out_if out_ch ();

  utf8_to_code_page_decoder #(.PAGES(PAGES)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  u2cp_result_checker #(.PAGES(PAGES)) oem_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic no_idle();
    return accepted_items >= CALM_FROM && accepted_items < CALM_TO;
  endfunction

  task automatic send_item(action_t act, logic [BYTE_W-1:0] b, logic [INDEX_W-1:0] idx,
                           logic [WORD_W-1:0] word);
    while (!no_idle() && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.byte_in    <= b;
    in_ch.load_index <= idx;
    in_ch.load_word  <= word;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    accepted_items++;
    if (act == ACT_DECODE || act == ACT_LOAD_TABLE || (act == ACT_LOAD_ID && idx < PAGES)) begin
      effective_items++;
    end
  endtask

  task automatic send_byte(logic [BYTE_W-1:0] b);
    send_item(ACT_DECODE, b, INDEX_W'($urandom_range(511)), WORD_W'($urandom_range('hFFFF)));
  endtask

  task automatic load_table(int idx, logic [WORD_W-1:0] word);
    shadow_words[idx] = word;
    send_item(ACT_LOAD_TABLE, BYTE_W'($urandom_range(255)), INDEX_W'(idx), word);
  endtask

  task automatic load_id(int slot, logic [WORD_W-1:0] word);
    if (slot < PAGES) shadow_ids[slot] = word;
    send_item(ACT_LOAD_ID, BYTE_W'($urandom_range(255)), INDEX_W'(slot), word);
  endtask

  function automatic logic [BYTE_W-1:0] utf8_byte(int cp, int len, int pos);
    if (pos == 0) begin
      case (len)
        1: begin
          return BYTE_W'(cp & 'h7F);
        end
        2: begin
          return BYTE_W'('hC0 | ((cp >> 6) & 'h1F));
        end
        3: begin
          return BYTE_W'('hE0 | ((cp >> 12) & 'h0F));
        end
        default: begin
          return BYTE_W'('hF0 | ((cp >> 18) & 'h07));
        end
      endcase
    end
    return BYTE_W'('h80 | ((cp >> (6 * (len - 1 - pos))) & 'h3F));
  endfunction

  task automatic send_utf8(int cp, int len, int count);
    for (int i = 0; i < count; i++) send_byte(utf8_byte(cp, len, i));
  endtask

  function automatic int natural_len(int cp);
    if (cp < 'h80) return 1;
    if (cp < 'h800) return 2;
    if (cp < 'h10000) return 3;
    return 4;
  endfunction

  function automatic int mapped_point();
    int limit;
    int slot;
    limit = (cur_used > PAGES) ? PAGES : int'(cur_used);
    slot = 0;
    while (slot < limit && shadow_ids[slot] != cur_page) slot++;
    if (slot >= limit) slot = $urandom_range(FILLED_PAGES - 1);
    return int'(shadow_words[slot*ENTRIES + $urandom_range(ENTRIES - 1)]);
  endfunction

  function automatic logic [WORD_W-1:0] table_word(int idx, int filled);
    int pick;
    pick = $urandom_range(99);
    if (filled > 0 && pick < 12) begin
      return shadow_words[(idx / ENTRIES) * ENTRIES + $urandom_range(filled - 1)];
    end
    if (pick < 30) return WORD_W'($urandom_range('h80, 'h7FF));
    if (pick < 80) return WORD_W'($urandom_range('h800, 'hFFFF));
    return WORD_W'($urandom_range('hFFFF));
  endfunction

  function automatic logic [WORD_W-1:0] id_word();
    case ($urandom_range(5))
      0: begin
        return 16'd437;
      end
      1: begin
        return 16'd0;
      end
      2: begin
        return 16'hFFFF;
      end
      3: begin
        return 16'd850;
      end
      4: begin
        return 16'd1252;
      end
      default: begin
        return WORD_W'($urandom_range('hFFFF));
      end
    endcase
  endfunction

  task automatic write_register(reg_idx_t r, logic [PDATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (r == REG_CODE_PAGE) begin
      cur_page = value[WORD_W-1:0];
    end else begin
      cur_used = value[PIU_W-1:0];
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_item();
    int               pick;
    int               cp;
    int               len;
    int               cut;
    logic [BYTE_W-1:0] tail;
    pick = $urandom_range(99);
    if (pick < 40) begin
      cp = mapped_point();
      len = natural_len(cp);
      send_utf8(cp, len, len);
    end else if (pick < 48) begin
      send_byte(BYTE_W'($urandom_range(1, 127)));
    end else if (pick < 54) begin
      if ($urandom_range(1)) begin
        cp = $urandom_range('h10000, 'h1FFFFF);
        send_utf8(cp, 4, 4);
      end else begin
        cp = $urandom_range('hD800, 'hDFFF);
        send_utf8(cp, 3, 3);
      end
    end else if (pick < 60) begin
      len = $urandom_range(2, 4);
      cp = $urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF);
      send_utf8(cp, len, len);
    end else if (pick < 67) begin
      cp = ($urandom_range(3) != 0) ? mapped_point() : $urandom_range('h80, 'h1FFFFF);
      len = natural_len(cp);
      if (len < 2) len = 2;
      cut = $urandom_range(1, len - 1);
      send_utf8(cp, len, cut);
      case ($urandom_range(3))
        0: begin
          tail = 8'h00;
        end
        1: begin
          tail = BYTE_W'($urandom_range(1, 127));
        end
        2: begin
          tail = 8'hC3;
        end
        default: begin
          tail = BYTE_W'($urandom_range('hF8, 'hFF));
        end
      endcase
      send_byte(tail);
    end else if (pick < 71) begin
      send_byte(8'h00);
    end else if (pick < 76) begin
      send_byte(BYTE_W'($urandom_range(1) ? $urandom_range('h80, 'hBF)
                                           : $urandom_range('hF8, 'hFF)));
    end else if (pick < 84) begin
      send_byte(BYTE_W'($urandom_range(255)));
    end else if (pick < 91) begin
      cut = $urandom_range(PAGES*ENTRIES - 1);
      load_table(cut, table_word(cut, (cut < FILLED_PAGES*ENTRIES) ? ENTRIES : 0));
    end else if (pick < 96) begin
      // Slots whose pages hold no table words keep ids that no lookup can match.
      cut = $urandom_range(PAGES + 1);
      if (cut >= FILLED_PAGES) cut = cut + PAGES - FILLED_PAGES;
      load_id(cut, id_word());
    end else begin
      send_item(ACT_UNUSED, BYTE_W'($urandom_range(255)), INDEX_W'($urandom_range(511)),
                WORD_W'($urandom_range('hFFFF)));
    end
  endtask

  initial begin
    int               hold_left;
    bit               hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && accepted_items >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (no_idle()) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    int               target;
    logic [WORD_W-1:0] word;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_DECODE;
    in_ch.byte_in    <= '0;
    in_ch.load_index <= '0;
    in_ch.load_word  <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    phase_pages = '{437, 0, 65535, 850, 65535, 437, 850, 1252, 437};
    phase_used  = '{4, 7, 2, 4, 1, 0, 5, 4, 3};
    cur_page = CODE_PAGE_RST;
    cur_used = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    settle();
    write_register(REG_CODE_PAGE, 437);
    write_register(REG_PAGES_IN_USE, 4);

    // Every page id is loaded, and so is every table word of the pages a lookup can reach.
    load_id(0, 16'd437);
    load_id(1, 16'hFFFF);
    load_id(2, 16'd2);
    load_id(3, 16'd3);
    for (int idx = 0; idx < FILLED_PAGES*ENTRIES; idx++) begin
      case (idx)
        0, 5: begin
          word = 16'h00E9;
        end
        1: begin
          word = 16'h20AC;
        end
        2: begin
          word = 16'hFFFF;
        end
        3: begin
          word = 16'h0080;
        end
        4: begin
          word = 16'h0000;
        end
        default: begin
          word = table_word(idx, idx % ENTRIES);
        end
      endcase
      load_table(idx, word);
    end

    send_byte(8'h41);
    send_utf8('hE9, 2, 2);
    send_utf8('hFFFF, 3, 3);
    send_utf8('h0, 2, 2);
    send_utf8('hD800, 3, 3);
    send_utf8('h1F600, 4, 4);
    send_utf8('h110000, 4, 4);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'hC3);
    send_byte(8'h41);
    send_byte(8'hE2);
    send_byte(8'h00);
    send_item(ACT_UNUSED, 8'hFF, 9'h1FF, 16'hFFFF);
    load_id(5, 16'h1234);
    send_byte(8'h00);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_register(REG_CODE_PAGE, phase_pages[ph]);
      write_register(REG_PAGES_IN_USE, phase_used[ph]);
      target = effective_items + PHASE_ITEMS;
      while (effective_items < target) random_item();
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
